FILE: sv/kct_pkg.sv
// Package for the keyed counter table: sizes, command and status codes,
// and the structs passed between the top level and the table.
// No dependencies.
package kct_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int KEY_BITS    = 32;
	localparam int COUNT_BITS  = 32;

	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int FIELD_W  = 32;
	localparam int OCC_W    = 6;
	localparam int USED_W   = $clog2(TABLE_DEPTH + 1);
	localparam int SUM_W    = ((COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W) + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_ADD    = 3'd2,
		CMD_SUB    = 3'd3,
		CMD_LOOKUP = 3'd4
	} kct_cmd_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EXISTS   = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_BADAMT   = 3'd3,
		ST_NEGATIVE = 3'd4,
		ST_FULL     = 3'd5,
		ST_OVERFLOW = 3'd6
	} kct_status_t;

	typedef struct packed {
		kct_cmd_code_t       cmd;
		logic [KEY_BITS-1:0] key;
		logic [FIELD_W-1:0]  amount;
	} kct_cmd_t;

	typedef struct packed {
		kct_status_t        status;
		logic               found;
		logic [FIELD_W-1:0] count;
		logic [OCC_W-1:0]   occupancy;
	} kct_rsp_t;

endpackage

FILE: sv/kct_ifs.sv
// Valid/ready channel interfaces for the keyed counter table:
// the request channel and the response channel.
// Depends on kct_pkg.
interface kct_req_if;
	import kct_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [FIELD_W-1:0] species_key;
	logic [FIELD_W-1:0] amount;

	modport source (output valid, output cmd, output species_key, output amount,
		input ready);
	modport sink (input valid, input cmd, input species_key, input amount,
		output ready);
endinterface

interface kct_rsp_if;
	import kct_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [FIELD_W-1:0]  count;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output found, output count,
		output occupancy, input ready);
	modport sink (input valid, input status, input found, input count,
		input occupancy, output ready);
endinterface

FILE: sv/kct_table.sv
// Key and count storage with parallel key match and the per-command update.
// Evaluates one registered request per cycle; commits when apply is high.
// Depends on kct_pkg.
module kct_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              apply,
	input  kct_pkg::kct_cmd_t req,
	output kct_pkg::kct_rsp_t rsp
);
	import kct_pkg::*;

	logic [KEY_BITS-1:0]   key_q [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] cnt_q [TABLE_DEPTH];
	logic [USED_W-1:0]     used_q;

	logic [TABLE_DEPTH-1:0] hit;
	logic [TABLE_DEPTH-1:0] last_sel;
	logic                   hit_any;
	logic [COUNT_BITS-1:0]  cur_cnt;
	logic [KEY_BITS-1:0]    last_key;
	logic [COUNT_BITS-1:0]  last_cnt;
	logic [SUM_W-1:0]       sum_ext;
	logic [SUM_W-1:0]       cur_ext;
	logic [SUM_W-1:0]       amt_ext;
	logic [SUM_W-1:0]       cmax_ext;
	logic                   full;
	logic                   do_ins;
	logic                   do_rem;
	logic                   do_upd;
	logic [COUNT_BITS-1:0]  new_cnt;
	logic [USED_W-1:0]      nxt_used;
	kct_status_t            status;
	logic                   found;
	logic [COUNT_BITS-1:0]  out_cnt;

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit[i]      = (USED_W'(i) < used_q) && (key_q[i] == req.key);
			last_sel[i] = (USED_W'(i) == used_q - USED_W'(1)) && (used_q != '0);
		end
	end

	always_comb begin
		cur_cnt  = '0;
		last_key = '0;
		last_cnt = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			cur_cnt  = cur_cnt  | (cnt_q[i] & {COUNT_BITS{hit[i]}});
			last_key = last_key | (key_q[i] & {KEY_BITS{last_sel[i]}});
			last_cnt = last_cnt | (cnt_q[i] & {COUNT_BITS{last_sel[i]}});
		end
	end

	assign hit_any  = |hit;
	assign full     = (used_q == USED_W'(TABLE_DEPTH));
	assign cur_ext  = SUM_W'(cur_cnt);
	assign amt_ext  = SUM_W'(req.amount);
	assign cmax_ext = SUM_W'({COUNT_BITS{1'b1}});
	assign sum_ext  = cur_ext + amt_ext;

	always_comb begin
		status   = ST_OK;
		found    = hit_any;
		out_cnt  = cur_cnt;
		nxt_used = used_q;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		do_upd   = 1'b0;
		new_cnt  = cur_cnt;
		if ((req.cmd == CMD_ADD || req.cmd == CMD_SUB) && req.amount == '0) begin
			status = ST_BADAMT;
		end else begin
			case (req.cmd)
				CMD_INSERT: begin
					if (hit_any) begin
						status = ST_EXISTS;
					end else if (full) begin
						status = ST_FULL;
					end else begin
						do_ins   = 1'b1;
						found    = 1'b1;
						out_cnt  = '0;
						nxt_used = used_q + USED_W'(1);
					end
				end
				CMD_REMOVE: begin
					if (!hit_any) begin
						status = ST_NOTFOUND;
					end else begin
						do_rem   = 1'b1;
						found    = 1'b0;
						out_cnt  = '0;
						nxt_used = used_q - USED_W'(1);
					end
				end
				CMD_ADD: begin
					if (!hit_any) begin
						status = ST_NOTFOUND;
					end else if (sum_ext > cmax_ext) begin
						status = ST_OVERFLOW;
					end else begin
						do_upd  = 1'b1;
						new_cnt = COUNT_BITS'(sum_ext);
						out_cnt = new_cnt;
					end
				end
				CMD_SUB: begin
					if (!hit_any) begin
						status = ST_NOTFOUND;
					end else if (cur_ext < amt_ext) begin
						status = ST_NEGATIVE;
					end else begin
						do_upd  = 1'b1;
						new_cnt = COUNT_BITS'(cur_ext - amt_ext);
						out_cnt = new_cnt;
					end
				end
				default: begin
					if (!hit_any) begin
						status = ST_NOTFOUND;
					end
				end
			endcase
		end
	end

	assign rsp.status    = status;
	assign rsp.found     = found;
	assign rsp.count     = FIELD_W'(out_cnt);
	assign rsp.occupancy = OCC_W'(nxt_used);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (apply) begin
			used_q <= nxt_used;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (do_ins && USED_W'(i) == used_q) begin
					key_q[i] <= req.key;
					cnt_q[i] <= '0;
				end
				if (do_rem && hit[i]) begin
					key_q[i] <= last_key;
					cnt_q[i] <= last_cnt;
				end
				if (do_upd && hit[i]) begin
					cnt_q[i] <= new_cnt;
				end
			end
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("occupancy above table depth");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("key held in more than one slot");

	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		apply && status != ST_OK |=> used_q == $past(used_q))
		else $error("failed request changed occupancy");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		apply && do_ins |=> used_q == $past(used_q) + USED_W'(1))
		else $error("insert did not grow occupancy");

endmodule

FILE: sv/keyed_counter_table.sv
// Keyed counter table top level: request register, table, response register.
// Depends on kct_pkg, kct_ifs (kct_req_if, kct_rsp_if) and kct_table.
//
//   channel  dir  payload                               handshake
//   req      in   cmd, species_key, amount              valid/ready
//   rsp      out  status, found, count, occupancy       valid/ready
//
// One request per cycle unless the response stalls.
// The match over all live slots and the update sit between the request
// register and the response register, so each request sees the table left
// by the one before it. A stalled response holds the request register;
// req.ready stays high while either register can move. Reset empties the table.
module keyed_counter_table (
	input logic clk,
	input logic arst_n,
	kct_req_if.sink   req,
	kct_rsp_if.source rsp
);
	import kct_pkg::*;

	logic     valid_s1;
	kct_cmd_t cmd_s1;
	logic     rsp_valid_q;
	kct_rsp_t rsp_q;
	kct_rsp_t result;
	logic     advance;
	logic     apply;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign apply     = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	kct_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.apply  (apply),
		.req    (cmd_s1),
		.rsp    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1.cmd    <= kct_cmd_code_t'(req.cmd);
			cmd_s1.key    <= KEY_BITS'(req.species_key);
			cmd_s1.amount <= req.amount;
		end
		if (apply) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_q.status;
	assign rsp.found     = rsp_q.found;
	assign rsp.count     = rsp_q.count;
	assign rsp.occupancy = rsp_q.occupancy;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1))
		else $error("stalled request lost");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		apply |=> rsp_valid_q)
		else $error("applied request gave no response");

	a_no_apply_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !apply)
		else $error("response overwritten while stalled");

endmodule
